>>> hw/rtl/cmcf_pkg.sv
package cmcf_pkg;

    // Vertex numbers and the vertex count share one fixed field width.
    localparam int VTX_W = 7;
    // floor(n/3) for n < 128 never exceeds 42.
    localparam int QUOTA_W = 6;
    // floor(n/3) == (n * 171) >> 9 for every n below 128.
    localparam int RECIP_MUL   = 171;
    localparam int RECIP_SHIFT = 9;
    localparam int PROD_W      = 16;
    localparam logic [VTX_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic {
        OP_EDGE   = 1'b0,
        OP_FINISH = 1'b1
    } cmcf_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_B,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_EMIT,
        ST_EMIT_EMPTY
    } cmcf_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr_all;
    } cmcf_mem_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [VTX_W-1:0] vertex;
        logic             last;
        logic             empty;
    } cmcf_emit_t;

endpackage

>>> hw/rtl/cmcf_adj_mem.sv
module cmcf_adj_mem #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cmcf_pkg::cmcf_mem_ctl_t         ctl,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0] bit_idx,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output logic [MAX_VERTICES-1:0]         rd_row
);
    import cmcf_pkg::*;

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [MAX_VERTICES-1:0] valid_next;
    logic [MAX_VERTICES-1:0] wr_mask;
    logic [MAX_VERTICES-1:0] wr_data;
    logic [MAX_VERTICES-1:0] rd_data_reg;
    logic                    rd_valid_reg;

    // A row never written since the last clear reads as zero: write it whole.
    always_comb begin
        wr_data = MAX_VERTICES'(1) << bit_idx;
        wr_mask = valid_reg[wr_addr] ? wr_data : {MAX_VERTICES{1'b1}};
    end

    always_comb begin
        valid_next = valid_reg;
        if (ctl.clr_all) begin
            valid_next = '0;
        end else if (ctl.wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                if (wr_mask[i]) begin
                    mem[wr_addr][i] <= wr_data[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

`ifndef SYNTH
    a_no_wr_on_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.wr_en && ctl.clr_all))
        else $error("row write during clear");

    a_no_rd_on_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.wr_en && ctl.rd_en))
        else $error("read and write in the same cycle");

    a_clear_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clr_all |=> (valid_reg == '0))
        else $error("row valid bits survive a clear");
`endif

endmodule

>>> hw/rtl/cmcf_seq.sv
module cmcf_seq #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_op,
    input  logic [cmcf_pkg::VTX_W-1:0]      first_v,
    input  logic [cmcf_pkg::VTX_W-1:0]      second_v,
    input  logic [cmcf_pkg::VTX_W-1:0]      n_eff,
    input  logic [cmcf_pkg::QUOTA_W-1:0]    quota,
    input  logic                            out_free,
    output cmcf_pkg::cmcf_emit_t            emit,
    output cmcf_pkg::cmcf_mem_ctl_t         mem_ctl,
    output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    output logic [$clog2(MAX_VERTICES)-1:0] bit_idx,
    output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  logic [MAX_VERTICES-1:0]         rd_row
);
    import cmcf_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CMP_W = (IDX_W + 1 > VTX_W) ? IDX_W + 1 : VTX_W;
    localparam logic [CMP_W-1:0] MAXV = CMP_W'(MAX_VERTICES);

    cmcf_state_t state_reg, state_next;

    logic [IDX_W-1:0]        a_reg, a_next;
    logic [IDX_W-1:0]        b_reg, b_next;
    logic [VTX_W-1:0]        n_reg, n_next;
    logic [QUOTA_W-1:0]      quota_reg, quota_next;
    logic [MAX_VERTICES-1:0] live_reg, live_next;
    logic [MAX_VERTICES-1:0] removed_reg, removed_next;
    logic [VTX_W-1:0]        j_reg, j_next;
    logic [QUOTA_W-1:0]      pairs_reg, pairs_next;
    logic [QUOTA_W-1:0]      cnt_reg, cnt_next;

    logic                    accept;
    logic                    is_finish;
    logic                    edge_ok;
    logic [IDX_W-1:0]        a_idx;
    logic [IDX_W-1:0]        b_idx;
    logic                    quota_zero;
    logic [IDX_W-1:0]        j_idx;
    logic [MAX_VERTICES-1:0] j_hot;
    logic [MAX_VERTICES-1:0] cand;
    logic                    cand_any;
    logic [IDX_W-1:0]        k_idx;
    logic [MAX_VERTICES-1:0] surv;
    logic                    surv_any;
    logic [IDX_W-1:0]        s_idx;
    logic                    scan_done;
    logic                    last_emit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_finish = (cmcf_op_t'(in_op) == OP_FINISH);

    assign edge_ok = (first_v != '0) && (CMP_W'(first_v) <= MAXV)
                  && (second_v != '0) && (CMP_W'(second_v) <= MAXV)
                  && (first_v != second_v);
    assign a_idx = IDX_W'(first_v - VTX_W'(1));
    assign b_idx = IDX_W'(second_v - VTX_W'(1));
    assign quota_zero = (n_eff < VTX_W'(3));

    assign j_idx = IDX_W'(j_reg);
    assign j_hot = MAX_VERTICES'(1) << j_idx;
    assign cand  = ~rd_row & ~removed_reg & live_reg & ~j_hot;
    assign surv  = live_reg & ~removed_reg;
    assign cand_any = |cand;
    assign surv_any = |surv;

    assign scan_done = (j_reg == n_reg) || (pairs_reg == quota_reg);
    assign last_emit = (cnt_reg == quota_reg - QUOTA_W'(1));

    // Lowest set bit of the candidate and survivor vectors.
    always_comb begin
        k_idx = '0;
        s_idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                k_idx = IDX_W'(i);
            end
            if (surv[i]) begin
                s_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_finish) begin
                        state_next = quota_zero ? ST_EMIT_EMPTY : ST_SCAN_RD;
                    end else if (edge_ok) begin
                        state_next = ST_EDGE_B;
                    end
                end
            end
            ST_EDGE_B: begin
                state_next = ST_IDLE;
            end
            ST_SCAN_RD: begin
                if (scan_done) begin
                    state_next = ST_EMIT;
                end else if (!removed_reg[j_idx]) begin
                    state_next = ST_SCAN_EVAL;
                end
            end
            ST_SCAN_EVAL: begin
                state_next = ST_SCAN_RD;
            end
            ST_EMIT: begin
                if (out_free && last_emit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_EMPTY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_ctl = '0;
        emit    = '0;
        wr_addr = b_reg;
        bit_idx = a_reg;
        rd_addr = j_idx;
        case (state_reg)
            ST_IDLE: begin
                mem_ctl.wr_en = accept && !is_finish && edge_ok;
                wr_addr       = a_idx;
                bit_idx       = b_idx;
            end
            ST_EDGE_B: begin
                mem_ctl.wr_en = 1'b1;
            end
            ST_SCAN_RD: begin
                mem_ctl.rd_en = !scan_done && !removed_reg[j_idx];
            end
            ST_EMIT: begin
                emit.valid      = out_free;
                emit.vertex     = VTX_W'(s_idx) + VTX_W'(1);
                emit.last       = last_emit;
                mem_ctl.clr_all = out_free && last_emit;
            end
            ST_EMIT_EMPTY: begin
                emit.valid      = out_free;
                emit.last       = 1'b1;
                emit.empty      = 1'b1;
                mem_ctl.clr_all = out_free;
            end
            default: begin
                mem_ctl = '0;
            end
        endcase
    end

    always_comb begin
        a_next       = a_reg;
        b_next       = b_reg;
        n_next       = n_reg;
        quota_next   = quota_reg;
        live_next    = live_reg;
        removed_next = removed_reg;
        j_next       = j_reg;
        pairs_next   = pairs_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    a_next     = a_idx;
                    b_next     = b_idx;
                    n_next     = n_eff;
                    quota_next = quota;
                    j_next     = '0;
                    pairs_next = '0;
                    cnt_next   = '0;
                    for (int i = 0; i < MAX_VERTICES; i++) begin
                        live_next[i] = (i < int'(n_eff));
                    end
                end
            end
            ST_SCAN_RD: begin
                if (!scan_done && removed_reg[j_idx]) begin
                    j_next = j_reg + VTX_W'(1);
                end
            end
            ST_SCAN_EVAL: begin
                if (cand_any) begin
                    removed_next = removed_reg | j_hot | (MAX_VERTICES'(1) << k_idx);
                    pairs_next   = pairs_reg + QUOTA_W'(1);
                end
                j_next = j_reg + VTX_W'(1);
            end
            ST_EMIT: begin
                if (out_free) begin
                    removed_next[s_idx] = 1'b1;
                    cnt_next            = cnt_reg + QUOTA_W'(1);
                    if (last_emit) begin
                        removed_next = '0;
                    end
                end
            end
            ST_EMIT_EMPTY: begin
                if (out_free) begin
                    removed_next = '0;
                end
            end
            default: begin
                j_next = j_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            removed_reg <= '0;
            pairs_reg   <= '0;
            quota_reg   <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            removed_reg <= removed_next;
            pairs_reg   <= pairs_next;
            quota_reg   <= quota_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        n_reg    <= n_next;
        live_reg <= live_next;
        j_reg    <= j_next;
    end

`ifndef SYNTH
    a_partner_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_EVAL && cand_any) |-> (k_idx != j_idx))
        else $error("vertex paired with itself");

    a_survivor_exists: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.valid && !emit.empty) |-> surv_any)
        else $error("result emitted with no surviving vertex");

    a_marks_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.valid && emit.last) |=> (removed_reg == '0))
        else $error("removal marks not cleared after finish");
`endif

endmodule

>>> hw/rtl/complement_matching_clique_finder.sv
// Channel   Dir  Transfer when        Payload
// s_        in   s_tvalid & s_tready  tuser: op; tdata: first_vertex, second_vertex
// m_        out  m_tvalid & m_tready  tdata: vertex; tlast: last; tuser: empty_res
// cfg_      in   cfg_wr_en            cfg_wr_data: vertex_count
//
// A stored edge writes one row per end, a dropped edge none. A finish scans rows 1..n
// on the one read port, reading and evaluating each unremoved row and skipping the
// others, until floor(n/3) pairs are gone or the rows run out, then emits floor(n/3)
// results (or one empty result) at one per cycle. Reset (synchronous, active low)
// clears control state, removal marks and row valid bits; an invalid row reads as
// zero. A stalled m_ side holds the result register and pauses the emit sequence.
module complement_matching_clique_finder #(
    parameter int MAX_VERTICES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [6:0] first_vertex, [13:7] second_vertex
    input  logic [0:0]  s_tuser,      // [0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [6:0] vertex
    output logic        m_tlast,
    output logic [0:0]  m_tuser,      // [0] empty_res

    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);
    import cmcf_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CMP_W = (IDX_W + 1 > VTX_W) ? IDX_W + 1 : VTX_W;

    logic [VTX_W-1:0]        vcount_reg, vcount_next;
    logic [VTX_W-1:0]        n_eff;
    logic [PROD_W-1:0]       quota_prod;
    logic [QUOTA_W-1:0]      quota;

    cmcf_emit_t              emit;
    cmcf_mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        bit_idx;
    logic [IDX_W-1:0]        rd_addr;
    logic [MAX_VERTICES-1:0] rd_row;
    logic                    out_free;

    logic                    m_valid_reg, m_valid_next;
    logic [VTX_W-1:0]        m_vertex_reg, m_vertex_next;
    logic                    m_last_reg, m_last_next;
    logic                    m_empty_reg, m_empty_next;

    // Vertex count register; the user must write it only while idle, the block does not enforce this.
    assign vcount_next = cfg_wr_en ? cfg_wr_data : vcount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else begin
            vcount_reg <= vcount_next;
        end
    end

    // Clamp the count to the matrix size, then divide by three through a
    // reciprocal multiply; the sequencer registers the quota at the finish.
    always_comb begin
        if (CMP_W'(vcount_reg) > CMP_W'(MAX_VERTICES)) begin
            n_eff = VTX_W'(MAX_VERTICES);
        end else begin
            n_eff = vcount_reg;
        end
        quota_prod = PROD_W'(n_eff) * PROD_W'(RECIP_MUL);
        quota      = QUOTA_W'(quota_prod >> RECIP_SHIFT);
    end

    // The result register is free when empty or when its transfer completes.
    assign out_free = !m_valid_reg || m_tready;

    cmcf_seq #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser[0]),
        .first_v  (s_tdata[6:0]),
        .second_v (s_tdata[13:7]),
        .n_eff    (n_eff),
        .quota    (quota),
        .out_free (out_free),
        .emit     (emit),
        .mem_ctl  (mem_ctl),
        .wr_addr  (wr_addr),
        .bit_idx  (bit_idx),
        .rd_addr  (rd_addr),
        .rd_row   (rd_row)
    );

    cmcf_adj_mem #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_adj_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .bit_idx (bit_idx),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    // Load a new result when the sequencer emits, drop the held one once taken.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_vertex_next = m_vertex_reg;
        m_last_next   = m_last_reg;
        m_empty_next  = m_empty_reg;
        if (emit.valid) begin
            m_valid_next  = 1'b1;
            m_vertex_next = emit.vertex;
            m_last_next   = emit.last;
            m_empty_next  = emit.empty;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_vertex_reg <= m_vertex_next;
        m_last_reg   <= m_last_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {1'b0, m_vertex_reg};
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_empty_reg;

endmodule

>>> tb/tb_complement_matching_clique_finder.sv
module tb_complement_matching_clique_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import cmcf_pkg::*;

    localparam int MAX_V        = 64;
    localparam int ITEM_TARGET  = 430;
    // An edge transfer finishes with its second row write; leave a margin on top.
    localparam int SETTLE_CYCLES = 12;

    // One result: a surviving vertex, the end-of-answer mark and the empty flag.
    typedef struct packed {
        logic [6:0] vertex;
        logic       last;
        logic       empty;
    } survivor_t;

    typedef enum logic {
        ROW_WRITE_COUNT,
        ROW_TRANSFER
    } row_kind_t;

    // A row of the directed table: either a vertex count write or one transfer,
    // optionally with its single result typed in by hand.
    typedef struct {
        row_kind_t  kind;
        cmcf_op_t   op;
        logic [6:0] a;
        logic [6:0] b;
        bit         typed;
        survivor_t  typed_res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [6:0] first_vertex, [13:7] second_vertex
    logic [0:0]  s_tuser = '0;      // [0] op

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [6:0] vertex
    logic        m_tlast;
    logic [0:0]  m_tuser;           // [0] empty_res

    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;

    // Predictor state: adjacency rows, removal marks and the vertex count.
    bit [MAX_V:0] linked [MAX_V+1];
    bit [MAX_V:0] gone;
    logic [6:0]   vcount = VCOUNT_RESET;

    survivor_t    fresh_survivors[$];    // answer of the finish just predicted
    survivor_t    pending_survivors[$];  // answers still to come out of m_
    stim_row_t    directed_rows[$];

    int           mismatches = 0;
    int           item_count = 0;
    bit           tx_steady  = 1'b0;
    bit           rx_steady  = 1'b0;
    int           stall_left = 0;

    always #4 aclk = ~aclk;

    complement_matching_clique_finder #(
        .MAX_VERTICES (MAX_V)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int next_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Store an edge unless an end is out of range or it is a self-loop.
    function automatic bit store_edge(input logic [6:0] a, input logic [6:0] b);
        if (a < 1 || a > MAX_V || b < 1 || b > MAX_V || a == b)
            return 1'b0;
        linked[a][b] = 1'b1;
        linked[b][a] = 1'b1;
        return 1'b1;
    endfunction

    // Greedy pair removal over the complement graph, then the first n/3 survivors.
    task automatic predict_finish();
        int n;
        int quota;
        int pairs;
        int taken;
        bit found;
        fresh_survivors.delete();
        n = (vcount > MAX_V) ? MAX_V : vcount;
        quota = n / 3;
        if (quota == 0) begin
            fresh_survivors.insert(fresh_survivors.size(), {7'd0, 1'b1, 1'b1});
        end else begin
            pairs = 0;
            found = 1'b1;
            while (pairs < quota && found) begin
                found = 1'b0;
                for (int j = 1; j <= n && !found; j++) begin
                    if (!gone[j]) begin
                        for (int k = 1; k <= n && !found; k++) begin
                            if (k != j && !gone[k] && !linked[j][k]) begin
                                gone[j] = 1'b1;
                                gone[k] = 1'b1;
                                found = 1'b1;
                            end
                        end
                    end
                end
                if (found)
                    pairs++;
            end
            // At least n - 2*(n/3) vertices survive, so the quota is always met.
            taken = 0;
            for (int i = 1; i <= n && taken < quota; i++) begin
                if (!gone[i]) begin
                    fresh_survivors.insert(fresh_survivors.size(),
                                           {7'(i), taken + 1 == quota, 1'b0});
                    taken++;
                end
            end
        end
        foreach (linked[i])
            linked[i] = '0;
        gone = '0;
    endtask

    // Present one transfer after a random gap and hold it until accepted;
    // predict on acceptance. Valid stays high on exit so bursts run back to back.
    task automatic send_transfer(input cmcf_op_t op, input logic [6:0] a,
                                 input logic [6:0] b, input bit typed,
                                 input survivor_t typed_res);
        int gap;
        gap = next_gap(tx_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, b, a};
        do @(posedge aclk); while (!s_tready);
        item_count++;
        if (op == OP_EDGE) begin
            void'(store_edge(a, b));
        end else begin
            predict_finish();
            if (typed)
                pending_survivors.insert(pending_survivors.size(), typed_res);
            else
                foreach (fresh_survivors[i])
                    pending_survivors.insert(pending_survivors.size(), fresh_survivors[i]);
        end
    endtask

    // Drop valid, drain every expected answer and let the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_survivors.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input logic [6:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        vcount = value;
    endtask

    function automatic void add_row(input row_kind_t kind, input cmcf_op_t op,
                                    input logic [6:0] a, input logic [6:0] b,
                                    input bit typed, input survivor_t res);
        stim_row_t row;
        row.kind      = kind;
        row.op        = op;
        row.a         = a;
        row.b         = b;
        row.typed     = typed;
        row.typed_res = res;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Random graph over the current vertex count, closed by a finish.
    task automatic build_graph(input int n_eff);
        int lim;
        int edges;
        int hi;
        logic [6:0] a;
        logic [6:0] b;
        hi = (n_eff < 1) ? 1 : n_eff;
        if (n_eff >= 3 && $urandom_range(0, 4) == 0) begin
            // Near-complete clique on the first few vertices: removal stops early.
            lim = (n_eff > 7) ? 7 : n_eff;
            for (int i = 1; i < lim; i++)
                for (int j = i + 1; j <= lim; j++)
                    if ($urandom_range(0, 7) != 0)
                        send_transfer(OP_EDGE, 7'(i), 7'(j), 1'b0, '0);
        end else begin
            edges = $urandom_range(0, (n_eff <= 8) ? 3 * n_eff + 2 : 24);
            repeat (edges) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // noise: ends of 0, above storage, self-loops
                        a = 7'($urandom_range(0, 127));
                        b = 7'($urandom_range(0, 127));
                    end
                    1: begin
                        // anywhere in storage, possibly above the count
                        a = 7'($urandom_range(1, MAX_V));
                        b = 7'($urandom_range(1, MAX_V));
                    end
                    default: begin
                        a = 7'($urandom_range(1, hi));
                        b = 7'($urandom_range(1, hi));
                    end
                endcase
                send_transfer(OP_EDGE, a, b, 1'b0, '0);
            end
        end
        send_transfer(OP_FINISH, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      1'b0, '0);
    endtask

    // Result side: random stalls, mostly short, with steady stretches.
    initial begin
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 299) == 0)
                rx_steady = !rx_steady;
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = next_gap(rx_steady);
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        survivor_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_survivors.size() == 0) begin
                report_mismatch($sformatf("unexpected result vertex %0d", m_tdata[6:0]));
            end else begin
                want = pending_survivors.pop_front();
                if (m_tuser[0] !== want.empty)
                    report_mismatch($sformatf("empty_res %b, want %b", m_tuser[0], want.empty));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                // The vertex field carries no meaning on an empty answer.
                if (!want.empty && m_tdata[6:0] !== want.vertex)
                    report_mismatch($sformatf("vertex %0d, want %0d",
                                              m_tdata[6:0], want.vertex));
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int n_eff;
        int r;
        logic [6:0] count;
        foreach (linked[i])
            linked[i] = '0;
        gone = '0;

        // Directed part: reset value first, then the corner cases.
        add_row(ROW_TRANSFER, OP_FINISH, 7'd0, 7'd0, 1'b0, '0);     // empty graph, 64
        add_row(ROW_WRITE_COUNT, OP_EDGE, 7'd2, 7'd0, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_FINISH, 7'd127, 7'd127, 1'b1, {7'd0, 1'b1, 1'b1});
        add_row(ROW_WRITE_COUNT, OP_EDGE, 7'd0, 7'd0, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_FINISH, 7'd0, 7'd0, 1'b1, {7'd0, 1'b1, 1'b1});
        add_row(ROW_WRITE_COUNT, OP_EDGE, 7'd1, 7'd0, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd1, 7'd1, 1'b0, '0);       // self-loop
        add_row(ROW_TRANSFER, OP_FINISH, 7'd0, 7'd0, 1'b1, {7'd0, 1'b1, 1'b1});
        // Path 1-2-3: the pair 1,3 goes, vertex 2 is the answer.
        add_row(ROW_WRITE_COUNT, OP_EDGE, 7'd3, 7'd0, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd1, 7'd2, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd2, 7'd3, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd2, 7'd1, 1'b0, '0);       // repeated edge
        add_row(ROW_TRANSFER, OP_EDGE, 7'd0, 7'd3, 1'b0, '0);       // end of zero
        add_row(ROW_TRANSFER, OP_EDGE, 7'd3, 7'd65, 1'b0, '0);      // end above storage
        add_row(ROW_TRANSFER, OP_EDGE, 7'd127, 7'd127, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_FINISH, 7'd0, 7'd0, 1'b1, {7'd2, 1'b1, 1'b0});
        // Count above storage behaves as 64.
        add_row(ROW_WRITE_COUNT, OP_EDGE, 7'd127, 7'd0, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd64, 7'd63, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd1, 7'd64, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd64, 7'd64, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_FINISH, 7'd0, 7'd0, 1'b0, '0);
        add_row(ROW_WRITE_COUNT, OP_EDGE, 7'd64, 7'd0, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd1, 7'd2, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd2, 7'd3, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd1, 7'd3, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_FINISH, 7'd0, 7'd0, 1'b0, '0);
        // Edge above the count is stored but plays no part.
        add_row(ROW_WRITE_COUNT, OP_EDGE, 7'd5, 7'd0, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd6, 7'd7, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_EDGE, 7'd1, 7'd2, 1'b0, '0);
        add_row(ROW_TRANSFER, OP_FINISH, 7'd0, 7'd0, 1'b0, '0);

        // Hold reset, then release it for good.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE_COUNT)
                write_vertex_count(directed_rows[i].a);
            else
                send_transfer(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                              directed_rows[i].typed, directed_rows[i].typed_res);
        end

        // Random part: each phase sets a count, then loads and finishes a few graphs.
        while (item_count < ITEM_TARGET) begin
            r = $urandom_range(0, 19);
            case (r)
                0:       count = 7'd1;
                1:       count = 7'd64;
                2:       count = 7'd0;
                3:       count = 7'($urandom_range(65, 127));
                4, 5:    count = 7'($urandom_range(21, 63));
                default: count = 7'($urandom_range(2, 20));
            endcase
            write_vertex_count(count);
            tx_steady = ($urandom_range(0, 4) == 0);
            n_eff = (count > MAX_V) ? MAX_V : count;
            repeat ($urandom_range(1, 3))
                build_graph(n_eff);
        end

        // Drain the last answers and let the block settle before judging.
        wait_idle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
